/* rtl/core/stack_bytecode_execute_unit_core_macros.svh */
// Assertion macros shared by the execute unit core RTL.
`ifndef STACK_BYTECODE_EXECUTE_UNIT_CORE_MACROS_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SBEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SBEU_ASSERT(label, prop, msg)
`define SBEU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/sbeu_pkg.sv */
// Types, widths and codes of the stack bytecode execute unit.
package sbeu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 64;
  localparam int KIND_W      = 4;
  localparam int COUNT_W     = 4;
  localparam int STATUS_W    = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [DEPTH_W-1:0]       depth_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 0,
    KIND_DROP   = 1,
    KIND_ADD    = 2,
    KIND_SUB    = 3,
    KIND_JUMP   = 4,
    KIND_JEQ    = 5,
    KIND_JNE    = 6,
    KIND_JGT    = 7,
    KIND_JGE    = 8,
    KIND_JLT    = 9,
    KIND_JLE    = 10,
    KIND_LOAD   = 11,
    KIND_STORE  = 12,
    KIND_RETURN = 13,
    KIND_ENTER  = 14
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 0,
    ST_UNDER = 1,
    ST_OVER  = 2,
    ST_SLOT  = 3,
    ST_KIND  = 4
  } status_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    word_t data;
  } wr_t;

endpackage

/* rtl/core/sbeu_if.sv */
// Command and result channel interfaces of the execute unit.
interface sbeu_cmd_if import sbeu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  word_t              operand;
  logic [COUNT_W-1:0] arg_count;
  logic [COUNT_W-1:0] local_count;

  modport source (output valid, kind, operand, arg_count, local_count, input ready);
  modport sink (input valid, kind, operand, arg_count, local_count, output ready);
endinterface

interface sbeu_res_if import sbeu_pkg::*; ();
  logic                valid;
  logic                ready;
  word_t               branch_offset;
  word_t               top_value;
  logic [DEPTH_W-1:0]  depth;
  logic [STATUS_W-1:0] status;
  logic                returned;

  modport source (output valid, branch_offset, top_value, depth, status, returned,
                  input ready);
  modport sink (input valid, branch_offset, top_value, depth, status, returned,
                output ready);
endinterface

/* rtl/core/sbeu_ram.sv */
// Generic RAM: one write port, two registered read ports, read before write.
module sbeu_ram #(
  parameter int  WIDTH  = 64,
  parameter int  DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_a,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* rtl/core/stack_bytecode_execute_unit_core.sv */
// Stack bytecode execute unit: one bytecode per transaction on a 64-bit operand stack.
//
// Usage:
//   cmd carries one bytecode per transaction (kind, operand, arg_count,
//   local_count); res returns exactly one result per bytecode, in order.
//   A transaction on cmd lands in the input stage; the bytecode executes
//   from there once the result register is free, and the result register
//   then drives res. One bytecode is accepted every cycle while res does not stall.
//   The rate is set by the stack RAM: its two registered read ports fetch
//   the entries below the top while the top of stack sits in a register,
//   and the RAM writes at most one entry per bytecode.
//   Reset clears depth and frame base; a valid bit per stack entry makes
//   entries never written read as zero, so no clearing pass is needed and
//   cmd.ready is high in the first cycle after reset.
//   When res stalls, the result register holds its transaction and one more
//   bytecode waits in the input stage; cmd.ready then drops until res moves.
//   Errors (underflow, overflow, slot out of range, unknown kind) report a
//   status and leave the stack untouched.
`include "stack_bytecode_execute_unit_core_macros.svh"

module stack_bytecode_execute_unit_core import sbeu_pkg::*; (
  input logic       clk,
  input logic       rst,
  sbeu_cmd_if.sink  cmd,
  sbeu_res_if.source res
);

  logic s1_valid;
  logic s2_valid;
  logic s2_free;
  logic exec;
  logic accept;

  logic [KIND_W-1:0]  s1_kind;
  word_t              s1_operand;
  logic [COUNT_W-1:0] s1_arg_count;
  logic [COUNT_W-1:0] s1_local_count;

  depth_t stack_depth, stack_depth_next, depth_upd;
  depth_t frame_base, frame_base_next, frame_upd;
  word_t  top, top_next, top_upd;

  status_t status_c;
  word_t   branch_c;
  word_t   result_top_c;
  logic    returned_c;

  wr_t wr_c, wr_g, wr_q;

  addr_t rd_addr_a, rd_addr_b, rd_addr_a_q, rd_addr_b_q;
  word_t ram_a, ram_b, val_a, val_b;
  logic [STACK_DEPTH-1:0] written;
  logic written_a_q, written_b_q;

  word_t               out_branch;
  word_t               out_top;
  depth_t              out_depth;
  logic [STATUS_W-1:0] out_status;
  logic                out_returned;

  assign s2_free   = !s2_valid || res.ready;
  assign exec      = s1_valid && s2_free;
  assign cmd.ready = !s1_valid || s2_free;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !exec);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind        <= cmd.kind;
      s1_operand     <= cmd.operand;
      s1_arg_count   <= cmd.arg_count;
      s1_local_count <= cmd.local_count;
    end
  end

  // forward the write of the previous cycle, zero for entries never written
  always_comb begin
    if (wr_q.we && wr_q.addr == rd_addr_a_q) begin
      val_a = wr_q.data;
    end else begin
      val_a = written_a_q ? word_t'(ram_a) : '0;
    end
    if (wr_q.we && wr_q.addr == rd_addr_b_q) begin
      val_b = wr_q.data;
    end else begin
      val_b = written_b_q ? word_t'(ram_b) : '0;
    end
  end

  always_comb begin
    kind_t                k;
    logic                 slot_ok;
    logic                 take;
    depth_t               span;
    depth_t               depth_m2;
    addr_t                slot_idx;
    logic [DEPTH_W:0]     grow;

    k        = kind_t'(s1_kind);
    span     = stack_depth - frame_base;
    depth_m2 = stack_depth - DEPTH_W'(2);
    slot_ok  = (frame_base < stack_depth) && ($unsigned(s1_operand) < WORD_W'(span));
    slot_idx = frame_base[ADDR_W-1:0] + s1_operand[ADDR_W-1:0];
    grow     = {1'b0, stack_depth} + (DEPTH_W+1)'(s1_local_count);
    take     = 1'b0;

    status_c   = ST_OK;
    branch_c   = '0;
    returned_c = 1'b0;
    depth_upd  = stack_depth;
    frame_upd  = frame_base;
    top_upd    = top;
    wr_c.we    = 1'b0;
    wr_c.addr  = stack_depth[ADDR_W-1:0];
    wr_c.data  = s1_operand;

    unique case (k) inside
      KIND_PUSH: begin
        if (stack_depth >= DEPTH_W'(STACK_DEPTH)) begin
          status_c = ST_OVER;
        end else begin
          wr_c.we   = 1'b1;
          depth_upd = stack_depth + DEPTH_W'(1);
          top_upd   = s1_operand;
        end
      end
      KIND_DROP: begin
        if (stack_depth == '0) begin
          status_c = ST_UNDER;
        end else begin
          depth_upd = stack_depth - DEPTH_W'(1);
          top_upd   = val_a;
        end
      end
      KIND_ADD, KIND_SUB: begin
        if (stack_depth < DEPTH_W'(2)) begin
          status_c = ST_UNDER;
        end else begin
          wr_c.we   = 1'b1;
          wr_c.addr = depth_m2[ADDR_W-1:0];
          wr_c.data = (k == KIND_ADD) ? val_a + top : val_a - top;
          depth_upd = stack_depth - DEPTH_W'(1);
          top_upd   = wr_c.data;
        end
      end
      KIND_JUMP: begin
        branch_c = s1_operand;
      end
      KIND_JEQ, KIND_JNE, KIND_JGT, KIND_JGE, KIND_JLT, KIND_JLE: begin
        if (stack_depth < DEPTH_W'(2)) begin
          status_c = ST_UNDER;
        end else begin
          case (k)
            KIND_JEQ: take = (val_a == top);
            KIND_JNE: take = (val_a != top);
            KIND_JGT: take = (top < val_a);
            KIND_JGE: take = !(val_a < top);
            KIND_JLT: take = (val_a < top);
            KIND_JLE: take = !(top < val_a);
            default:  take = 1'b0;
          endcase
          branch_c  = take ? s1_operand : '0;
          depth_upd = depth_m2;
          top_upd   = val_b;
        end
      end
      KIND_LOAD: begin
        if (!slot_ok) begin
          status_c = ST_SLOT;
        end else if (stack_depth >= DEPTH_W'(STACK_DEPTH)) begin
          status_c = ST_OVER;
        end else begin
          wr_c.we   = 1'b1;
          wr_c.data = val_a;
          depth_upd = stack_depth + DEPTH_W'(1);
          top_upd   = val_a;
        end
      end
      KIND_STORE: begin
        if (!slot_ok) begin
          status_c = ST_SLOT;
        end else begin
          wr_c.we   = 1'b1;
          wr_c.addr = slot_idx;
          wr_c.data = top;
          depth_upd = stack_depth - DEPTH_W'(1);
          top_upd   = (slot_idx == depth_m2[ADDR_W-1:0]) ? top : val_a;
        end
      end
      KIND_RETURN: begin
        if (stack_depth == '0) begin
          status_c = ST_UNDER;
        end else begin
          returned_c = 1'b1;
          depth_upd  = (frame_base < stack_depth) ? frame_base : stack_depth;
          frame_upd  = '0;
          top_upd    = val_a;
        end
      end
      KIND_ENTER: begin
        if (DEPTH_W'(s1_arg_count) > stack_depth) begin
          status_c = ST_UNDER;
        end else if (grow > (DEPTH_W+1)'(STACK_DEPTH)) begin
          status_c = ST_OVER;
        end else begin
          frame_upd = stack_depth - DEPTH_W'(s1_arg_count);
          depth_upd = grow[DEPTH_W-1:0];
          top_upd   = val_a;
        end
      end
      default: begin
        status_c = ST_KIND;
      end
    endcase

    if (depth_upd == '0) begin
      top_upd = '0;
    end
    result_top_c = returned_c ? top : top_upd;
  end

  always_comb begin
    stack_depth_next = exec ? depth_upd : stack_depth;
    frame_base_next  = exec ? frame_upd : frame_base;
    top_next         = exec ? top_upd : top;
    wr_g             = wr_c;
    wr_g.we          = wr_c.we && exec;
  end

  // fetch the entries the next bytecode in the input stage needs
  always_comb begin
    logic [KIND_W-1:0]  ik;
    word_t              iop;
    logic [COUNT_W-1:0] iloc;
    depth_t             ret_depth;
    depth_t             ret_top;
    depth_t             ent_top;
    depth_t             below_top;
    depth_t             third;
    addr_t              slot_addr;

    ik        = accept ? cmd.kind : s1_kind;
    iop       = accept ? cmd.operand : s1_operand;
    iloc      = accept ? cmd.local_count : s1_local_count;
    ret_depth = (frame_base_next < stack_depth_next) ? frame_base_next : stack_depth_next;
    ret_top   = ret_depth - DEPTH_W'(1);
    ent_top   = stack_depth_next + DEPTH_W'(iloc) - DEPTH_W'(1);
    below_top = stack_depth_next - DEPTH_W'(2);
    third     = stack_depth_next - DEPTH_W'(3);
    slot_addr = frame_base_next[ADDR_W-1:0] + iop[ADDR_W-1:0];

    rd_addr_b = third[ADDR_W-1:0];
    unique case (kind_t'(ik)) inside
      KIND_LOAD:   rd_addr_a = slot_addr;
      KIND_RETURN: rd_addr_a = ret_top[ADDR_W-1:0];
      KIND_ENTER:  rd_addr_a = ent_top[ADDR_W-1:0];
      default:     rd_addr_a = below_top[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth <= '0;
      frame_base  <= '0;
      top         <= '0;
      wr_q        <= '0;
      written     <= '0;
    end else begin
      stack_depth <= stack_depth_next;
      frame_base  <= frame_base_next;
      top         <= top_next;
      wr_q        <= wr_g;
      if (wr_g.we) begin
        written[wr_g.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_a_q <= rd_addr_a;
    rd_addr_b_q <= rd_addr_b;
    written_a_q <= written[rd_addr_a];
    written_b_q <= written[rd_addr_b];
  end

  sbeu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .we        (wr_g.we),
    .wr_addr   (wr_g.addr),
    .wr_data   (wr_g.data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (exec) begin
      s2_valid <= 1'b1;
    end else if (res.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_branch   <= branch_c;
      out_top      <= result_top_c;
      out_depth    <= depth_upd;
      out_status   <= status_c;
      out_returned <= returned_c;
    end
  end

  assign res.valid         = s2_valid;
  assign res.branch_offset = out_branch;
  assign res.top_value     = out_top;
  assign res.depth         = out_depth;
  assign res.status        = out_status;
  assign res.returned      = out_returned;

  `SBEU_ASSERT(a_empty_top, stack_depth == '0 |-> top == '0, "top register not zero on empty stack")
  `SBEU_ASSERT_NEXT(a_err_hold, exec && status_c != ST_OK, $stable(stack_depth) && $stable(frame_base) && !wr_q.we, "state changed by failing bytecode")
  `SBEU_ASSERT(a_stall_hold, s2_valid && !res.ready |-> !exec, "bytecode executed while result stalled")
  `SBEU_ASSERT(a_err_fields, s2_valid && res.status != ST_OK |-> !res.returned && res.branch_offset == '0, "error result carries branch or return")

endmodule

/* dv/sbeu_tb_pkg.sv */
// Scoreboard for the stack bytecode execute unit: stack predictor, expected results, checks.
package sbeu_tb_pkg;
  import sbeu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 4'hF;
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    word_t   branch_offset;
    word_t   top_value;
    depth_t  depth;
    status_t status;
    logic    returned;
  } exec_result_t;

  class exec_scoreboard;
    word_t        entries [STACK_DEPTH];
    int unsigned  sp;
    int unsigned  base;
    exec_result_t pending_results [$];
    int unsigned  mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      sp = 0;
      base = 0;
      mismatches = 0;
    endfunction

    function bit frame_slot(word_t slot, output int unsigned idx);
      logic [WORD_W-1:0] u;
      u = slot;
      idx = 0;
      if (base >= sp) return 1'b0;
      if (u >= 64'(sp - base)) return 1'b0;
      idx = base + u[ADDR_W-1:0];
      return 1'b1;
    endfunction

    function void note_bytecode(logic [KIND_W-1:0] kind, word_t operand,
                                logic [COUNT_W-1:0] nargs, logic [COUNT_W-1:0] nlocals);
      int unsigned  d;
      int unsigned  idx;
      word_t        lhs;
      word_t        rhs;
      word_t        ret_val;
      logic         take;
      exec_result_t r;
      d = sp;
      r = '0;
      r.status = ST_OK;
      ret_val = '0;
      take = 1'b0;
      idx = 0;
      case (kind)
        KIND_PUSH: begin
          if (d >= STACK_DEPTH) begin
            r.status = ST_OVER;
          end else begin
            entries[d] = operand;
            sp = d + 1;
          end
        end
        KIND_DROP: begin
          if (d < 1) r.status = ST_UNDER;
          else sp = d - 1;
        end
        KIND_ADD, KIND_SUB: begin
          if (d < 2) begin
            r.status = ST_UNDER;
          end else begin
            lhs = entries[d-2];
            rhs = entries[d-1];
            entries[d-2] = (kind == KIND_ADD) ? lhs + rhs : lhs - rhs;
            sp = d - 1;
          end
        end
        KIND_JUMP: begin
          r.branch_offset = operand;
        end
        KIND_JEQ, KIND_JNE, KIND_JGT, KIND_JGE, KIND_JLT, KIND_JLE: begin
          if (d < 2) begin
            r.status = ST_UNDER;
          end else begin
            lhs = entries[d-2];
            rhs = entries[d-1];
            case (kind)
              KIND_JEQ: take = (lhs == rhs);
              KIND_JNE: take = (lhs != rhs);
              KIND_JGT: take = (lhs > rhs);
              KIND_JGE: take = (lhs >= rhs);
              KIND_JLT: take = (lhs < rhs);
              default:  take = (lhs <= rhs);
            endcase
            r.branch_offset = take ? operand : '0;
            sp = d - 2;
          end
        end
        KIND_LOAD: begin
          if (!frame_slot(operand, idx)) begin
            r.status = ST_SLOT;
          end else if (d >= STACK_DEPTH) begin
            r.status = ST_OVER;
          end else begin
            entries[d] = entries[idx];
            sp = d + 1;
          end
        end
        KIND_STORE: begin
          if (!frame_slot(operand, idx)) begin
            r.status = ST_SLOT;
          end else begin
            entries[idx] = entries[d-1];
            sp = d - 1;
          end
        end
        KIND_RETURN: begin
          if (d < 1) begin
            r.status = ST_UNDER;
          end else begin
            ret_val = entries[d-1];
            sp = (base < d) ? base : d;
            base = 0;
            r.returned = 1'b1;
          end
        end
        KIND_ENTER: begin
          if (nargs > d) begin
            r.status = ST_UNDER;
          end else if (d + nlocals > STACK_DEPTH) begin
            r.status = ST_OVER;
          end else begin
            base = d - nargs;
            sp = d + nlocals;
          end
        end
        default: begin
          r.status = ST_KIND;
        end
      endcase
      r.depth = depth_t'(sp);
      if (r.returned) r.top_value = ret_val;
      else r.top_value = (sp > 0) ? entries[sp-1] : '0;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(word_t branch_offset, word_t top_value, depth_t depth,
                      logic [STATUS_W-1:0] status, logic returned);
      exec_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction: depth %0d status %0d",
                                  depth, status));
        return;
      end
      e = pending_results.pop_front();
      if (branch_offset !== e.branch_offset)
        report_mismatch($sformatf("branch_offset %0d, expected %0d",
                                  branch_offset, e.branch_offset));
      if (top_value !== e.top_value)
        report_mismatch($sformatf("top_value %0d, expected %0d", top_value, e.top_value));
      if (depth !== e.depth)
        report_mismatch($sformatf("depth %0d, expected %0d", depth, e.depth));
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
      if (returned !== e.returned)
        report_mismatch($sformatf("returned %0b, expected %0b", returned, e.returned));
    endtask
  endclass

endpackage

/* dv/tb_stack_bytecode_execute_unit_core.sv */
// Testbench top for the stack bytecode execute unit: directed and random bytecode streams.
module tb_stack_bytecode_execute_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbeu_pkg::*;
  import sbeu_tb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 850;

  // indexed by kind encoding, last entry is the unused code; rows: grow, shrink, mixed
  int kind_weight [3][16] = '{
    '{35, 3, 4, 4, 3, 1, 1, 1, 1, 1, 1, 15, 4, 1, 20, 1},
    '{10, 12, 8, 8, 3, 3, 3, 3, 3, 3, 3, 6, 8, 5, 3, 1},
    '{18, 6, 5, 5, 3, 2, 2, 2, 2, 2, 2, 10, 8, 3, 6, 2}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  bit             no_gaps = 1'b0;
  int unsigned    idle_cycles = 0;
  exec_scoreboard sb = new();

  sbeu_cmd_if cmd();
  sbeu_res_if res();

  stack_bytecode_execute_unit_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always #6ns clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return word_t'(int'($urandom_range(0, 8)) - 4);
      3:       return WORD_MAX;
      4:       return WORD_MIN;
      5:       return word_t'(-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_bytecode(input logic [KIND_W-1:0] kind, input word_t operand,
                               input logic [COUNT_W-1:0] nargs,
                               input logic [COUNT_W-1:0] nlocals);
    int unsigned gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.kind        <= kind;
    cmd.operand     <= operand;
    cmd.arg_count   <= nargs;
    cmd.local_count <= nlocals;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sb.note_bytecode(kind, operand, nargs, nlocals);
  endtask

  task automatic random_bytecode(input int mode);
    int unsigned        total;
    int unsigned        pick;
    int unsigned        k;
    int unsigned        room;
    logic [KIND_W-1:0]  kind;
    word_t              operand;
    logic [COUNT_W-1:0] nargs;
    logic [COUNT_W-1:0] nlocals;
    total = 0;
    for (int i = 0; i < 16; i++) total += kind_weight[mode][i];
    pick = $urandom_range(0, total - 1);
    k = 0;
    while (pick >= kind_weight[mode][k]) begin
      pick -= kind_weight[mode][k];
      k++;
    end
    kind = k[KIND_W-1:0];
    operand = rand_word();
    nargs = 4'($urandom);
    nlocals = 4'($urandom);
    room = (sb.sp > sb.base) ? sb.sp - sb.base : 0;
    case (kind)
      KIND_PUSH: begin
        if ($urandom_range(0, 2) != 0) operand = word_t'(int'($urandom_range(0, 6)) - 3);
      end
      KIND_LOAD, KIND_STORE: begin
        if (room > 0 && $urandom_range(0, 9) < 8) begin
          operand = word_t'($urandom_range(0, room - 1));
        end else begin
          case ($urandom_range(0, 2))
            0: operand = word_t'(room + $urandom_range(0, 3));
            1: operand = word_t'(-int'($urandom_range(1, 4)));
            default: ;
          endcase
        end
      end
      KIND_ENTER: begin
        if ($urandom_range(0, 3) != 0)
          nargs = 4'($urandom_range(0, (sb.sp < 15) ? sb.sp : 15));
      end
      default: ;
    endcase
    send_bytecode(kind, operand, nargs, nlocals);
  endtask

  initial begin
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int unsigned n;
      res.ready <= 1'b1;
      if (no_gaps) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 8)) @(posedge clk);
        n = gap_len();
        if (n > 0) begin
          res.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.branch_offset, res.top_value, res.depth, res.status, res.returned);
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("stack_bytecode_execute_unit_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_left;
    int          mode;
    cmd.valid       <= 1'b0;
    cmd.kind        <= KIND_PUSH;
    cmd.operand     <= '0;
    cmd.arg_count   <= '0;
    cmd.local_count <= '0;
    phase_left = 0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // errors on an empty stack, then jumps to the extreme offsets
    send_bytecode(KIND_DROP, '0, '0, '0);
    send_bytecode(KIND_ADD, '0, '0, '0);
    send_bytecode(KIND_JLT, 64'sd9, '0, '0);
    send_bytecode(KIND_RETURN, '0, '0, '0);
    send_bytecode(KIND_LOAD, '0, '0, '0);
    send_bytecode(KIND_STORE, '0, '0, '0);
    send_bytecode(KIND_ENTER, '0, 4'd15, 4'd3);
    send_bytecode(KIND_UNUSED, word_t'(-1), 4'd15, 4'd15);
    send_bytecode(KIND_JUMP, WORD_MAX, '0, '0);
    send_bytecode(KIND_JUMP, WORD_MIN, '0, '0);
    // wrapping arithmetic at the extremes
    send_bytecode(KIND_PUSH, WORD_MAX, '0, '0);
    send_bytecode(KIND_PUSH, 64'sd1, '0, '0);
    send_bytecode(KIND_ADD, '0, '0, '0);
    send_bytecode(KIND_PUSH, 64'sd1, '0, '0);
    send_bytecode(KIND_SUB, '0, '0, '0);
    send_bytecode(KIND_PUSH, word_t'(-1), '0, '0);
    send_bytecode(KIND_JGT, 64'sd5, '0, '0);
    // frame slots: negative, past the top, valid
    send_bytecode(KIND_ENTER, '0, 4'd0, 4'd15);
    send_bytecode(KIND_LOAD, word_t'(-1), '0, '0);
    send_bytecode(KIND_STORE, 64'sd15, '0, '0);
    send_bytecode(KIND_STORE, 64'sd3, '0, '0);
    send_bytecode(KIND_PUSH, WORD_MIN, '0, '0);
    send_bytecode(KIND_STORE, '0, '0, '0);
    send_bytecode(KIND_LOAD, '0, '0, '0);
    send_bytecode(KIND_LOAD, '0, '0, '0);
    send_bytecode(KIND_JEQ, 64'sd100, '0, '0);
    send_bytecode(KIND_RETURN, '0, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = (mode == 0) ? $urandom_range(150, 250) : $urandom_range(40, 150);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      random_bytecode(mode);
    end
    cmd.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("stack_bytecode_execute_unit_core verification clean");
    end else begin
      $display("stack_bytecode_execute_unit_core verification failed");
    end
    $finish;
  end

endmodule

/* stack_bytecode_execute_unit_core.f */
+incdir+rtl/core
rtl/core/sbeu_pkg.sv
rtl/core/sbeu_if.sv
rtl/core/sbeu_ram.sv
rtl/core/stack_bytecode_execute_unit_core.sv
dv/sbeu_tb_pkg.sv
dv/tb_stack_bytecode_execute_unit_core.sv
